[rtl/core/npw_pkg.sv]
// Shared types and constants for the nearest-peak window map.
// No dependencies; imported by npw_ctrl, npw_dp and the top module of the block.
`default_nettype none

package npw_pkg;

	// Grid geometry
	localparam int GRID_W_LG = 8;
	localparam int GRID_H_LG = 8;
	localparam int ADDR_W    = GRID_W_LG + GRID_H_LG;
	localparam int CELLS     = 1 << ADDR_W;

	// Field widths
	localparam int POS_W   = 8;
	localparam int LABEL_W = 13;
	localparam int OFS_W   = 10;
	localparam int CFG_W   = 9;
	localparam int SHIFT_W = 4;
	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int WON_W   = 10;
	localparam int TOTAL_W = 24;
	localparam int CELL_W  = LABEL_W + 2 * OFS_W;

	// Internal arithmetic widths
	localparam int CRD_W   = 10;  // signed cell coordinate
	localparam int DELTA_W = 5;   // signed window offset, -15..15
	localparam int HALF_W  = 4;   // window half size, 2..15
	localparam int WD2_W   = 10;  // window squared distance
	localparam int SQ_W    = 21;  // stored squared distance

	localparam logic [CFG_W-1:0]   GRID_WIDTH  = CFG_W'(1 << GRID_W_LG);
	localparam logic [CFG_W-1:0]   GRID_HEIGHT = CFG_W'(1 << GRID_H_LG);
	localparam logic [SHIFT_W-1:0] MAX_SHIFT   = SHIFT_W'(13);
	localparam logic [WON_W-1:0]   MAX_WON     = WON_W'(961);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;

	// Register reset values
	localparam logic [CFG_W-1:0]   WIDTH_RST  = CFG_W'(256);
	localparam logic [CFG_W-1:0]   HEIGHT_RST = CFG_W'(256);
	localparam logic [SHIFT_W-1:0] SHIFT_RST  = SHIFT_W'(2);

	// Operation codes
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_SHIFT = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // latch a new item
		logic clr_wr;   // write one cell of the clearing sweep
		logic issue;    // issue the next window cell
		logic rd_cell;  // read the cell of a read item
		logic load;     // move the result into the output register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_done;   // sweep is at the last cell
		logic last_cell;  // window counters at the last cell
		logic pipe_busy;  // place pipeline still holds cells
		logic out_free;   // output register can take a result
	} dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/npw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module npw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/npw_ctrl.sv]
// Controller state machine for the nearest-peak window map.
// Depends on npw_pkg; drives the datapath in npw_dp.
`default_nettype none

module npw_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [npw_pkg::OP_W-1:0]       operation,
	output logic                                in_ready,
	input  wire npw_pkg::dp_stat_t              stat,
	output npw_pkg::ctrl_cmd_t                  cmd
);

	import npw_pkg::*;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_PLACE = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Commands
	always_comb begin
		cmd         = '0;
		cmd.accept  = accept;
		cmd.clr_wr  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.issue   = (state_q == ST_PLACE);
		cmd.rd_cell = (state_q == ST_READ);
		cmd.load    = (state_q == ST_FIN) && stat.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_PLACE: state_d = ST_PLACE;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_FIN;
			end
			ST_PLACE: begin
				if (stat.last_cell) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = ST_FIN;
			end
			ST_READ: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken while busy");
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !stat.pipe_busy)
		else $error("result finished with cells still in flight");
	a_drain_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DRAIN || state_q == ST_FIN))
		else $error("drain left to a wrong state");
`endif

endmodule

`default_nettype wire

[rtl/core/npw_dp.sv]
// Datapath: configuration registers, window counters, cell pipeline,
// map RAM and output register. Depends on npw_pkg and npw_ram.
`default_nettype none

module npw_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [npw_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [npw_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic [npw_pkg::OP_W-1:0]       operation,
	input  wire logic [npw_pkg::POS_W-1:0]      pos_x,
	input  wire logic [npw_pkg::POS_W-1:0]      pos_y,
	input  wire logic [npw_pkg::LABEL_W-1:0]    peak_label,
	input  wire npw_pkg::ctrl_cmd_t             cmd,
	output npw_pkg::dp_stat_t                   stat,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [npw_pkg::LABEL_W-1:0]         cell_label,
	output logic signed [npw_pkg::OFS_W-1:0]    offset_x,
	output logic signed [npw_pkg::OFS_W-1:0]    offset_y,
	output logic [npw_pkg::WON_W-1:0]           cells_won,
	output logic [npw_pkg::TOTAL_W-1:0]         total_won
);

	import npw_pkg::*;

	// Configuration registers
	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [SHIFT_W-1:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			shift_q  <= SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_WINDOW_SHIFT: shift_q  <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective image size and clamped shift
	logic [CFG_W-1:0]   w_eff;
	logic [CFG_W-1:0]   h_eff;
	logic [SHIFT_W-1:0] sh_new;
	logic [CFG_W-1:0]   dim_max;

	assign w_eff   = (width_q < GRID_WIDTH) ? width_q : GRID_WIDTH;
	assign h_eff   = (height_q < GRID_HEIGHT) ? height_q : GRID_HEIGHT;
	assign sh_new  = (shift_q > MAX_SHIFT) ? MAX_SHIFT : shift_q;
	assign dim_max = (width_q > height_q) ? width_q : height_q;

	// Item registers
	logic [OP_W-1:0]    op_q;
	logic [POS_W-1:0]   px_q;
	logic [POS_W-1:0]   py_q;
	logic [LABEL_W-1:0] label_q;
	logic [SHIFT_W-1:0] sh_q;
	logic [HALF_W-1:0]  half_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= operation;
			px_q    <= pos_x;
			py_q    <= pos_y;
			label_q <= peak_label;
			sh_q    <= sh_new;
			half_q  <= HALF_W'(sh_new) + HALF_W'(2);
		end
	end

	// Clearing sweep: cell index and fill value; reset value is the reset max dim
	logic [ADDR_W-1:0] clr_idx_q;
	logic [OFS_W-1:0]  clr_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			clr_val_q <= OFS_W'((WIDTH_RST > HEIGHT_RST) ? WIDTH_RST : HEIGHT_RST);
		end else begin
			if (cmd.accept) begin
				clr_val_q <= OFS_W'(dim_max);
			end
			if (cmd.clr_wr) begin
				clr_idx_q <= clr_idx_q + ADDR_W'(1);
			end
		end
	end

	// Window counters
	logic signed [DELTA_W-1:0] dx_q;
	logic signed [DELTA_W-1:0] dy_q;
	logic signed [DELTA_W-1:0] half_s;
	logic signed [DELTA_W-1:0] half_new_s;

	assign half_s     = signed'(DELTA_W'(half_q));
	assign half_new_s = signed'(DELTA_W'(sh_new) + DELTA_W'(2));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dx_q <= -half_new_s;
			dy_q <= -half_new_s;
		end else if (cmd.issue) begin
			if (dy_q == half_s) begin
				dy_q <= -half_s;
				dx_q <= dx_q + DELTA_W'(1);
			end else begin
				dy_q <= dy_q + DELTA_W'(1);
			end
		end
	end

	// Cell coordinates of the current window position
	logic signed [CRD_W-1:0] cx;
	logic signed [CRD_W-1:0] cy;
	logic                    cell_inb;
	logic [ADDR_W-1:0]       cell_addr;

	always_comb begin
		cx = signed'(CRD_W'(px_q)) - signed'(CRD_W'(sh_q)) + CRD_W'(dx_q);
		cy = signed'(CRD_W'(py_q)) - signed'(CRD_W'(sh_q)) + CRD_W'(dy_q);
		cell_inb = (cx >= 0) && (cx < signed'(CRD_W'(w_eff)))
			&& (cy >= 0) && (cy < signed'(CRD_W'(h_eff)));
		cell_addr = {cy[GRID_H_LG-1:0], cx[GRID_W_LG-1:0]};
	end

	// Map RAM: {label, offset x, offset y}
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	npw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Stage 1: stored data arrives; stage 2: compare and write back
	logic                      valid_s1, valid_s2;
	logic                      inb_s1, inb_s2;
	logic [ADDR_W-1:0]         addr_s1, addr_s2;
	logic signed [DELTA_W-1:0] dx_s1, dx_s2;
	logic signed [DELTA_W-1:0] dy_s1, dy_s2;
	logic [WD2_W-1:0]          wd2_s2;
	logic [SQ_W-1:0]           sd2_s2;

	logic signed [OFS_W-1:0]     sx, sy;
	logic signed [2*OFS_W-1:0]   sxx, syy;
	logic signed [2*DELTA_W-1:0] dxx, dyy;
	logic                        win_s2;

	assign sx  = signed'(ram_rdata[2*OFS_W-1:OFS_W]);
	assign sy  = signed'(ram_rdata[OFS_W-1:0]);
	assign sxx = sx * sx;
	assign syy = sy * sy;
	assign dxx = dx_s1 * dx_s1;
	assign dyy = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		inb_s1  <= cell_inb;
		addr_s1 <= cell_addr;
		dx_s1   <= dx_q;
		dy_s1   <= dy_q;
		inb_s2  <= inb_s1;
		addr_s2 <= addr_s1;
		dx_s2   <= dx_s1;
		dy_s2   <= dy_s1;
		wd2_s2  <= WD2_W'(unsigned'(dxx)) + WD2_W'(unsigned'(dyy));
		sd2_s2  <= SQ_W'(unsigned'(sxx)) + SQ_W'(unsigned'(syy));
	end

	assign win_s2 = valid_s2 && inb_s2 && (SQ_W'(wd2_s2) <= sd2_s2);

	// RAM port selection
	always_comb begin
		ram_re    = (cmd.issue && cell_inb) || cmd.rd_cell;
		ram_raddr = cmd.rd_cell ? {py_q, px_q} : cell_addr;
		ram_we    = cmd.clr_wr || win_s2;
		if (cmd.clr_wr) begin
			ram_waddr = clr_idx_q;
			ram_wdata = {LABEL_W'(0), clr_val_q, clr_val_q};
		end else begin
			ram_waddr = addr_s2;
			ram_wdata = {label_q, OFS_W'(dx_s2), OFS_W'(dy_s2)};
		end
	end

	// Cells won by the current place, and running total
	logic [WON_W-1:0]   won_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_sat;

	assign total_sum = (TOTAL_W + 1)'(total_q) + (TOTAL_W + 1)'(won_q);
	assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			won_q <= '0;
		end else if (cmd.accept) begin
			won_q <= '0;
		end else if (win_s2) begin
			won_q <= won_q + WON_W'(1);
		end
	end

	// Read bounds check
	logic rd_inb;
	assign rd_inb = (CFG_W'(px_q) < w_eff) && (CFG_W'(py_q) < h_eff);

	// Output register and total counter
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_CLEAR) begin
					total_q <= '0;
				end else if (op_q == OP_PLACE) begin
					total_q <= total_sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cell_label <= '0;
			offset_x   <= '0;
			offset_y   <= '0;
			cells_won  <= '0;
			total_won  <= total_q;
			case (op_q)
				OP_CLEAR: begin
					total_won <= '0;
				end
				OP_PLACE: begin
					cells_won <= won_q;
					total_won <= total_sat;
				end
				OP_READ: begin
					if (rd_inb) begin
						cell_label <= ram_rdata[CELL_W-1:2*OFS_W];
						offset_x   <= sx;
						offset_y   <= sy;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// Status to controller
	always_comb begin
		stat           = '0;
		stat.clr_done  = (clr_idx_q == '1);
		stat.last_cell = (dx_q == half_s) && (dy_q == half_s);
		stat.pipe_busy = valid_s1 || valid_s2;
		stat.out_free  = !out_valid_q || out_ready;
	end

`ifndef SYNTH
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && valid_s2))
		else $error("clearing sweep overlaps a window write");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || out_ready))
		else $error("result loaded over one not yet taken");
	a_won_bound: assert property (@(posedge clk) disable iff (!arst_n)
		won_q <= MAX_WON)
		else $error("cells won exceeds the largest window");
`endif

endmodule

`default_nettype wire

[rtl/core/nearest_peak_window_map.sv]
// Nearest-peak window map. Place: one map RAM read-modify-write per window cell inside
// the image, window half size h = min(shift,13)+2. Clear: one cell written per cycle.
// The result is registered in the same cycle that in_ready returns; one item in flight
// at a time; a stalled output holds in_ready low. After reset the whole map is swept
// with in_ready low; config writes are taken during the sweep. Depends on npw_pkg,
// npw_ctrl, npw_dp.
`default_nettype none

module nearest_peak_window_map (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [npw_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [npw_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [npw_pkg::OP_W-1:0]       operation,
	input  wire logic [npw_pkg::POS_W-1:0]      pos_x,
	input  wire logic [npw_pkg::POS_W-1:0]      pos_y,
	input  wire logic [npw_pkg::LABEL_W-1:0]    peak_label,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [npw_pkg::LABEL_W-1:0]         cell_label,
	output logic signed [npw_pkg::OFS_W-1:0]    offset_x,
	output logic signed [npw_pkg::OFS_W-1:0]    offset_y,
	output logic [npw_pkg::WON_W-1:0]           cells_won,
	output logic [npw_pkg::TOTAL_W-1:0]         total_won
);

	import npw_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	npw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	npw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.peak_label (peak_label),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_label (cell_label),
		.offset_x   (offset_x),
		.offset_y   (offset_y),
		.cells_won  (cells_won),
		.total_won  (total_won)
	);

endmodule

`default_nettype wire

[verif/npw_map_checker.sv]
// Scoreboard for the nearest-peak window map: follows the register port and both item channels,
// keeps its own copy of the map and compares every result field by field.
// Depends on npw_pkg.
module npw_map_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [npw_pkg::IDX_W-1:0]           cfg_index,
	input  logic [npw_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [npw_pkg::OP_W-1:0]            operation,
	input  logic [npw_pkg::POS_W-1:0]           pos_x,
	input  logic [npw_pkg::POS_W-1:0]           pos_y,
	input  logic [npw_pkg::LABEL_W-1:0]         peak_label,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [npw_pkg::LABEL_W-1:0]         cell_label,
	input  logic signed [npw_pkg::OFS_W-1:0]    offset_x,
	input  logic signed [npw_pkg::OFS_W-1:0]    offset_y,
	input  logic [npw_pkg::WON_W-1:0]           cells_won,
	input  logic [npw_pkg::TOTAL_W-1:0]         total_won,
	output int                                  mismatches,
	output int                                  pending,
	output int                                  checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import npw_pkg::*;

	localparam int WON_SAT = 1023;

	typedef struct packed {
		logic [LABEL_W-1:0]       label;
		logic signed [OFS_W-1:0]  ox;
		logic signed [OFS_W-1:0]  oy;
		logic [WON_W-1:0]         won;
		logic [TOTAL_W-1:0]       total;
	} map_result_t;

	// Shadow registers and shadow map
	logic [CFG_W-1:0]          img_w;
	logic [CFG_W-1:0]          img_h;
	logic [SHIFT_W-1:0]        win_shift;
	logic [LABEL_W-1:0]        label_map [CELLS];
	logic signed [OFS_W-1:0]   ofs_x_map [CELLS];
	logic signed [OFS_W-1:0]   ofs_y_map [CELLS];
	int unsigned               won_total;

	map_result_t               expected_q [$];

	// Every cell back to no owner, both offsets at the larger image dimension
	function automatic void wipe_map();
		logic [CFG_W-1:0] far;
		far = (img_w > img_h) ? img_w : img_h;
		for (int i = 0; i < CELLS; i++) begin
			label_map[i] = '0;
			ofs_x_map[i] = OFS_W'(far);
			ofs_y_map[i] = OFS_W'(far);
		end
		won_total = 0;
	endfunction

	// Applies one item to the shadow map and returns the result it must give
	function automatic map_result_t map_apply(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [LABEL_W-1:0] lab);
		map_result_t r;
		int px, py, sh, half, ew, eh, cx, cy, sx, sy, idx;
		int unsigned won;
		r = '0;
		px = x;
		py = y;
		ew = (img_w < GRID_WIDTH) ? img_w : GRID_WIDTH;
		eh = (img_h < GRID_HEIGHT) ? img_h : GRID_HEIGHT;
		case (op)
			OP_CLEAR: begin
				wipe_map();
			end
			OP_PLACE: begin
				sh = (win_shift > MAX_SHIFT) ? MAX_SHIFT : win_shift;
				half = sh + 2;
				won = 0;
				for (int dx = -half; dx <= half; dx++) begin
					for (int dy = -half; dy <= half; dy++) begin
						cx = px - sh + dx;
						cy = py - sh + dy;
						if (cx < 0 || cx >= ew || cy < 0 || cy >= eh)
							continue;
						idx = (cy << GRID_W_LG) + cx;
						sx = ofs_x_map[idx];
						sy = ofs_y_map[idx];
						// ties go to the later peak
						if (dx * dx + dy * dy <= sx * sx + sy * sy) begin
							label_map[idx] = lab;
							ofs_x_map[idx] = OFS_W'(dx);
							ofs_y_map[idx] = OFS_W'(dy);
							won++;
						end
					end
				end
				won_total = (won_total + won > TOTAL_MAX) ? TOTAL_MAX : won_total + won;
				r.won = (won > WON_SAT) ? WON_W'(WON_SAT) : WON_W'(won);
			end
			OP_READ: begin
				if (px < ew && py < eh) begin
					idx = (py << GRID_W_LG) + px;
					r.label = label_map[idx];
					r.ox = ofs_x_map[idx];
					r.oy = ofs_y_map[idx];
				end
			end
			default: ;  // spare code leaves the map alone
		endcase
		r.total = TOTAL_W'(won_total);
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t checker: result %0d %s expected %0d, got %0d",
				$time, checked, name, want, got);
		end
	endtask

	// Sample both channels at the clock edge; results are checked before new items are added
	always @(posedge clk or negedge arst_n) begin
		map_result_t want_r;
		if (!arst_n) begin
			img_w = WIDTH_RST;
			img_h = HEIGHT_RST;
			win_shift = SHIFT_RST;
			wipe_map();
			expected_q.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  img_w = cfg_data;
					REG_IMAGE_HEIGHT: img_h = cfg_data;
					REG_WINDOW_SHIFT: win_shift = cfg_data[SHIFT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					$display("%0t checker: result with no item pending: label %0d ofs %0d/%0d won %0d total %0d",
						$time, cell_label, offset_x, offset_y, cells_won, total_won);
				end else begin
					want_r = expected_q.pop_front();
					check_field("cell_label", want_r.label, cell_label);
					check_field("offset_x", want_r.ox, offset_x);
					check_field("offset_y", want_r.oy, offset_y);
					check_field("cells_won", want_r.won, cells_won);
					check_field("total_won", want_r.total, total_won);
					checked++;
				end
			end
			if (in_valid && in_ready)
				expected_q.insert(expected_q.size(),
					map_apply(operation, pos_x, pos_y, peak_label));
			pending = expected_q.size();
		end
	end

endmodule

[verif/tb_top.sv]
// Top of the nearest-peak window map testbench: clock, reset, register writes, item stimulus
// and the verdict. Depends on npw_pkg, nearest_peak_window_map and npw_map_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import npw_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int QUIET_LIMIT     = 300000;  // well above the length of a clear
	localparam int DRAIN_CYCLES    = 1000;
	localparam int ITEMS_PER_PHASE = 200;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         operation = '0;
	logic [POS_W-1:0]        pos_x = '0;
	logic [POS_W-1:0]        pos_y = '0;
	logic [LABEL_W-1:0]      peak_label = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [LABEL_W-1:0]      cell_label;
	logic signed [OFS_W-1:0] offset_x;
	logic signed [OFS_W-1:0] offset_y;
	logic [WON_W-1:0]        cells_won;
	logic [TOTAL_W-1:0]      total_won;

	int  mismatches;
	int  pending;
	int  checked;
	bit  calm = 1'b0;
	bit  in_taken;
	int  quiet_cycles;
	int  n_clear, n_place, n_read, n_spare, n_settings;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	nearest_peak_window_map u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.peak_label (peak_label),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_label (cell_label),
		.offset_x   (offset_x),
		.offset_y   (offset_y),
		.cells_won  (cells_won),
		.total_won  (total_won)
	);

	npw_map_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.peak_label (peak_label),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_label (cell_label),
		.offset_x   (offset_x),
		.offset_y   (offset_y),
		.cells_won  (cells_won),
		.total_won  (total_won),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	// Handshake record for the stimulus and the watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			in_taken <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top: no item moved for %0d cycles", QUIET_LIMIT);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Result side stalls at random, about 23 percent of the time, never while calm
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 23);

	function automatic logic [POS_W-1:0] clamp8(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : POS_W'(v);
	endfunction

	// One past the furthest peak position whose window can still touch the image, capped at 255
	function automatic int reach(input int extent, input int sh);
		return (extent + 2 * sh + 2 > 255) ? 255 : extent + 2 * sh + 2;
	endfunction

	// One item; called and returns at a falling edge, valid held until taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [LABEL_W-1:0] lab);
		if (!calm && $urandom_range(0, 99) < 23) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		pos_x = x;
		pos_y = y;
		peak_label = lab;
		do @(negedge clk); while (!in_taken);
		case (op)
			OP_CLEAR: n_clear++;
			OP_PLACE: n_place++;
			OP_READ:  n_read++;
			default:  n_spare++;
		endcase
	endtask

	// Hold off new items until every result is back
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [SHIFT_W-1:0] s);
		cfg_we = 1'b1;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = w;
		@(negedge clk);
		cfg_index = REG_IMAGE_HEIGHT;
		cfg_data = h;
		@(negedge clk);
		cfg_index = REG_WINDOW_SHIFT;
		cfg_data = CFG_W'(s);
		@(negedge clk);
		cfg_we = 1'b0;
		n_settings++;
	endtask

	// Random phase: peaks cluster around a hub so windows compete, reads follow the peaks
	task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [SHIFT_W-1:0] s, input bit wipe);
		int sh, half, ew, eh, hub_x, hub_y, last_x, last_y, k, j, i2;
		logic [POS_W-1:0] x, y;
		logic [LABEL_W-1:0] lab;
		settle();
		write_config(w, h, s);
		if (wipe)
			send_item(OP_CLEAR, POS_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 255)),
				LABEL_W'($urandom_range(0, 8191)));
		sh = (s > MAX_SHIFT) ? MAX_SHIFT : s;
		half = sh + 2;
		ew = (w < GRID_WIDTH) ? w : GRID_WIDTH;
		eh = (h < GRID_HEIGHT) ? h : GRID_HEIGHT;
		hub_x = $urandom_range(0, reach(ew, sh));
		hub_y = $urandom_range(0, reach(eh, sh));
		last_x = hub_x;
		last_y = hub_y;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			k = $urandom_range(0, 99);
			j = $urandom_range(0, 9);
			lab = ($urandom_range(0, 4) == 0) ? LABEL_W'($urandom_range(0, 8191))
				: LABEL_W'($urandom_range(1, 4096));
			if (k < 3) begin
				send_item(OP_SPARE, POS_W'($urandom_range(0, 255)),
					POS_W'($urandom_range(0, 255)), lab);
			end else if (k < 48) begin
				if (j < 5) begin
					i2 = $urandom_range(0, 16);
					x = clamp8(hub_x + i2 - 8);
					i2 = $urandom_range(0, 16);
					y = clamp8(hub_y + i2 - 8);
				end else if (j < 9) begin
					x = POS_W'($urandom_range(0, reach(ew, sh)));
					y = POS_W'($urandom_range(0, reach(eh, sh)));
				end else begin
					x = POS_W'($urandom_range(0, 255));
					y = POS_W'($urandom_range(0, 255));
				end
				last_x = x;
				last_y = y;
				send_item(OP_PLACE, x, y, lab);
			end else begin
				if (j < 6) begin
					i2 = $urandom_range(0, 2 * half);
					x = clamp8(last_x - sh + i2 - half);
					i2 = $urandom_range(0, 2 * half);
					y = clamp8(last_y - sh + i2 - half);
				end else if (j < 8) begin
					x = POS_W'($urandom_range(0, (ew > 0) ? ew - 1 : 0));
					y = POS_W'($urandom_range(0, (eh > 0) ? eh - 1 : 0));
				end else begin
					x = POS_W'($urandom_range(0, 255));
					y = POS_W'($urandom_range(0, 255));
				end
				send_item(OP_READ, x, y, lab);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// block sweeps the map after reset
		while (!in_ready) @(negedge clk);

		// Reset settings: fresh map, window edges, top label, tie, spare code, clear
		send_item(OP_READ, 8'd0, 8'd0, 13'd1);
		send_item(OP_SPARE, 8'd255, 8'd255, 13'h1FFF);
		send_item(OP_PLACE, 8'd0, 8'd0, 13'd1);
		send_item(OP_PLACE, 8'd255, 8'd255, 13'h1FFF);
		send_item(OP_PLACE, 8'd128, 8'd128, 13'd4096);
		send_item(OP_PLACE, 8'd128, 8'd128, 13'd2);
		send_item(OP_READ, 8'd126, 8'd126, 13'd0);
		send_item(OP_READ, 8'd255, 8'd255, 13'd0);
		send_item(OP_READ, 8'd0, 8'd0, 13'd0);
		send_item(OP_READ, 8'd128, 8'd128, 13'h1FFF);
		send_item(OP_CLEAR, 8'd255, 8'd255, 13'h1FFF);
		send_item(OP_READ, 8'd200, 8'd17, 13'd0);

		// Image larger than the grid and a shift above the cap
		settle();
		write_config(9'd511, 9'd300, 4'd15);
		send_item(OP_CLEAR, 8'd0, 8'd0, 13'd0);
		send_item(OP_PLACE, 8'd128, 8'd128, 13'd77);
		send_item(OP_PLACE, 8'd13, 8'd0, 13'd4095);
		send_item(OP_READ, 8'd100, 8'd100, 13'd0);
		send_item(OP_READ, 8'd255, 8'd255, 13'd0);

		// Empty image
		settle();
		write_config(9'd0, 9'd0, 4'd0);
		send_item(OP_PLACE, 8'd5, 8'd5, 13'd9);
		send_item(OP_READ, 8'd0, 8'd0, 13'd0);

		// Read past the image edge
		settle();
		write_config(9'd10, 9'd256, 4'd1);
		send_item(OP_READ, 8'd20, 8'd3, 13'd0);
		send_item(OP_PLACE, 8'd9, 8'd3, 13'd11);
		send_item(OP_READ, 8'd8, 8'd2, 13'd0);

		// Random phases over a spread of settings, the first one without stalls
		calm = 1'b1;
		run_phase(9'd256, 9'd256, 4'd0, 1'b1);
		calm = 1'b0;
		run_phase(9'd1, 9'd1, MAX_SHIFT, 1'b0);
		run_phase(9'd511, 9'd511, 4'd15, 1'b1);
		run_phase(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)),
			SHIFT_W'($urandom_range(0, 4)), 1'b0);
		run_phase(9'd300, 9'd7, 4'd3, 1'b1);
		run_phase(CFG_W'($urandom_range(0, 511)), CFG_W'($urandom_range(0, 511)),
			SHIFT_W'($urandom_range(0, 15)), 1'b0);
		run_phase(9'd64, 9'd256, 4'd1, 1'b1);
		run_phase(9'd256, 9'd1, SHIFT_W'($urandom_range(0, 15)), 1'b0);

		// Drain, then give results that should never come time to show up
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("tb_top: sent %0d items: %0d clears, %0d places, %0d reads, %0d spare codes",
			n_clear + n_place + n_read + n_spare, n_clear, n_place, n_read, n_spare);
		$display("tb_top: %0d register settings, %0d results compared", n_settings, checked);
		if (mismatches == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
